@@ hdl/gaenv_pkg.sv @@
`timescale 1ns / 1ps

package gaenv_pkg;

  // Fixed-point format of the envelope and level (Q1.16, one = 2^16)
  localparam int ENV_FRAC_BITS = 16;
  localparam int ENV_W         = ENV_FRAC_BITS + 1;
  localparam logic [ENV_W-1:0] ENV_ONE = ENV_W'(1 << ENV_FRAC_BITS);

  // Times at or below this many 1/65536 s make the envelope jump
  localparam int ENV_JUMP_LIMIT = 6;

  // Field and register widths
  localparam int DT_W       = 16;
  localparam int ATK_W      = 17;
  localparam int REL_W      = 19;
  localparam int SPD_W      = 17;
  localparam int AMT_W      = 17;
  localparam int PHASE_OUT_W = 32;

  // Phase format: Q.22 rings, increment = round(dt*speed / 2^11)
  localparam int PHASE_FRAC_BITS = 22;
  localparam int PHASE_SHIFT     = 11;

  // Serial divider: (dt << 16) / time
  localparam int DIV_W  = DT_W + ENV_FRAC_BITS;
  localparam int DIV_CW = $clog2(DIV_W);

  // Shared multiplier operand widths
  localparam int MUL_A_W = 17;
  localparam int MUL_B_W = 18;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = REL_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ATTACK  = 2'd0,
    CFG_RELEASE = 2'd1,
    CFG_SPEED   = 2'd2,
    CFG_AMOUNT  = 2'd3
  } cfg_idx_e;

  localparam logic [ATK_W-1:0] ATK_RESET = ATK_W'(3277);
  localparam logic [REL_W-1:0] REL_RESET = REL_W'(52429);
  localparam logic [SPD_W-1:0] SPD_RESET = SPD_W'(32768);
  localparam logic [AMT_W-1:0] AMT_RESET = AMT_W'(0);

  typedef struct packed {
    logic            gate_level;
    logic            trigger_level;
    logic [DT_W-1:0] time_step;
  } in_req_t;

  typedef struct packed {
    logic [ENV_W-1:0]       envelope;
    logic [ENV_W-1:0]       level;
    logic [PHASE_OUT_W-1:0] drift_phase;
  } out_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_ENV,
    ST_SQ,
    ST_PHASE,
    ST_SMOOTH,
    ST_CURVE,
    ST_BLEND,
    ST_LEVEL
  } state_e;

  typedef enum logic [1:0] {
    MUL_SQ,
    MUL_PH,
    MUL_SM,
    MUL_BL
  } mul_sel_e;

  typedef struct packed {
    logic     accept;
    logic     env_upd;
    logic     cap_q;
    logic     cap_phase;
    logic     cap_m;
    logic     load_out;
    mul_sel_e mul_sel;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

@@ hdl/gaenv_div.sv @@
`timescale 1ns / 1ps

module gaenv_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [gaenv_pkg::DIV_W-1:0]   numer_i,
  input  logic [gaenv_pkg::REL_W-1:0]   denom_i,
  output logic                          done_o,
  output logic [gaenv_pkg::DIV_W-1:0]   quot_o
);
  import gaenv_pkg::*;

  logic              busy_q, busy_d;
  logic [DIV_CW-1:0] cnt_q, cnt_d;
  logic [REL_W-1:0]  rem_q, rem_d;
  logic [REL_W-1:0]  den_q;
  logic [DIV_W-1:0]  quo_q, quo_d;
  logic [REL_W:0]    trial;
  logic [REL_W:0]    diff;
  logic              fits;

  // One restoring step: shift in the next numerator bit, subtract if it fits
  always_comb begin
    trial  = {rem_q, quo_q[DIV_W-1]};
    diff   = trial - {1'b0, den_q};
    fits   = trial >= {1'b0, den_q};
    rem_d  = fits ? diff[REL_W-1:0] : trial[REL_W-1:0];
    quo_d  = {quo_q[DIV_W-2:0], fits};
    cnt_d  = cnt_q + DIV_CW'(1);
    busy_d = busy_q && (cnt_q != DIV_CW'(DIV_W - 1));
  end

  assign done_o = busy_q && (cnt_q == DIV_CW'(DIV_W - 1));
  assign quot_o = quo_q;

  // Sequence control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // Remainder and quotient shift register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= numer_i;
      den_q <= denom_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

endmodule

@@ hdl/gaenv_ctrl.sv @@
`timescale 1ns / 1ps

module gaenv_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  gaenv_pkg::sts_t sts_i,
  output gaenv_pkg::cmd_t cmd_o
);
  import gaenv_pkg::*;

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.mul_sel = MUL_SQ;
    in_stall_o    = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts_i.div_done) begin
          state_d = ST_ENV;
        end
      end
      ST_ENV: begin
        cmd_o.env_upd = 1'b1;
        state_d       = ST_SQ;
      end
      ST_SQ: begin
        cmd_o.mul_sel = MUL_SQ;
        state_d       = ST_PHASE;
      end
      ST_PHASE: begin
        cmd_o.cap_q   = 1'b1;
        cmd_o.mul_sel = MUL_PH;
        state_d       = ST_SMOOTH;
      end
      ST_SMOOTH: begin
        cmd_o.cap_phase = 1'b1;
        cmd_o.mul_sel   = MUL_SM;
        state_d         = ST_CURVE;
      end
      ST_CURVE: begin
        cmd_o.cap_m = 1'b1;
        state_d     = ST_BLEND;
      end
      ST_BLEND: begin
        cmd_o.mul_sel = MUL_BL;
        state_d       = ST_LEVEL;
      end
      ST_LEVEL: begin
        // hold the blend product until the output register frees up
        cmd_o.mul_sel = MUL_BL;
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

@@ hdl/gaenv_dp.sv @@
`timescale 1ns / 1ps

module gaenv_dp #(
  parameter int PHASE_WRAP_RINGS = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [gaenv_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [gaenv_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  gaenv_pkg::in_req_t                in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output gaenv_pkg::out_req_t               out_data_o,
  input  gaenv_pkg::cmd_t                   cmd_i,
  output gaenv_pkg::sts_t                   sts_o
);
  import gaenv_pkg::*;

  localparam int PH_W   = $clog2(PHASE_WRAP_RINGS) + PHASE_FRAC_BITS;
  localparam int EXT_W  = (PH_W > PHASE_OUT_W) ? PH_W : PHASE_OUT_W;
  localparam int INC_W  = PROD_W - PHASE_SHIFT;
  localparam logic [PH_W:0] PH_MOD =
    (PH_W + 1)'(PHASE_WRAP_RINGS) << PHASE_FRAC_BITS;
  localparam logic [PROD_W-1:0] PH_RND = PROD_W'(1) << (PHASE_SHIFT - 1);
  localparam logic [PROD_W-1:0] ENV_RND = PROD_W'(1) << (ENV_FRAC_BITS - 1);
  localparam logic [MUL_B_W-1:0] SM_THREE = MUL_B_W'(3) << ENV_FRAC_BITS;
  localparam int RND_W = PROD_W - ENV_FRAC_BITS;

  // Round half up and drop the fraction of a product
  function automatic logic [RND_W-1:0] rnd_frac(input logic [PROD_W-1:0] p);
    logic [PROD_W-1:0] s;
    s = p + ENV_RND;
    return s[PROD_W-1:ENV_FRAC_BITS];
  endfunction

  // Configuration and state registers
  logic [ATK_W-1:0] attack_q;
  logic [REL_W-1:0] release_q;
  logic [SPD_W-1:0] speed_q;
  logic [AMT_W-1:0] amount_q;
  logic             gate_held_q, trig_last_q, armed_q, active_q;
  logic [DT_W-1:0]  dt_q;
  logic [ENV_W-1:0] env_q, env_d;
  logic             armed_d;
  logic [PH_W-1:0]  phase_q;
  logic [ENV_W-1:0] sq_q, m_q;
  logic [PROD_W-1:0] prod_q;
  logic             out_valid_q;
  out_req_t         out_q;

  // Edge detection on the incoming request
  logic os_edge, active_in;
  logic [REL_W-1:0] denom;
  logic div_done;
  logic [DIV_W-1:0] quot;

  always_comb begin
    os_edge = armed_q;
    if (in_data_i.gate_level && !gate_held_q) begin
      os_edge = 1'b0;
    end
    if (in_data_i.trigger_level && !trig_last_q) begin
      os_edge = 1'b1;
    end
    active_in = in_data_i.gate_level || os_edge;
    denom     = active_in ? REL_W'(attack_q) : release_q;
  end

  gaenv_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.accept),
    .numer_i ({in_data_i.time_step, ENV_FRAC_BITS'(0)}),
    .denom_i (denom),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  // Envelope step: rise by the quotient or fall by it, with jumps and clamps
  logic [DIV_W:0] env_sum;

  always_comb begin
    env_sum = {1'b0, DIV_W'(env_q)} + {1'b0, quot};
    env_d   = env_q;
    armed_d = armed_q;
    if (active_q) begin
      if (attack_q <= ATK_W'(ENV_JUMP_LIMIT) || env_sum >= (DIV_W + 1)'(ENV_ONE)) begin
        env_d   = ENV_ONE;
        armed_d = 1'b0;
      end else begin
        env_d = env_sum[ENV_W-1:0];
      end
    end else begin
      if (release_q <= REL_W'(ENV_JUMP_LIMIT)) begin
        env_d = '0;
      end else if (DIV_W'(env_q) > quot) begin
        env_d = env_q - quot[ENV_W-1:0];
      end else begin
        env_d = '0;
      end
    end
  end

  // Shared multiplier with operand selection
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [ENV_W-1:0]   amount_sat;

  always_comb begin
    amount_sat = (amount_q > ENV_ONE) ? ENV_ONE : amount_q;
    case (cmd_i.mul_sel)
      MUL_SQ: begin
        mul_a = env_q;
        mul_b = MUL_B_W'(env_q);
      end
      MUL_PH: begin
        mul_a = speed_q;
        mul_b = MUL_B_W'(dt_q);
      end
      MUL_SM: begin
        mul_a = sq_q;
        mul_b = SM_THREE - {env_q, 1'b0};
      end
      MUL_BL: begin
        mul_a = ENV_ONE - amount_sat;
        mul_b = MUL_B_W'(ENV_ONE - m_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  // Phase advance with one conditional wrap
  logic [PROD_W-1:0] ph_rnd;
  logic [INC_W-1:0]  ph_inc;
  logic [PH_W:0]     ph_sum;
  logic [PH_W-1:0]   phase_d;

  always_comb begin
    ph_rnd  = prod_q + PH_RND;
    ph_inc  = ph_rnd[PROD_W-1:PHASE_SHIFT];
    ph_sum  = {1'b0, phase_q} + (PH_W + 1)'(ph_inc);
    phase_d = (ph_sum >= PH_MOD) ? PH_W'(ph_sum - PH_MOD) : ph_sum[PH_W-1:0];
  end

  // Smoothstep and level from the product register
  logic [RND_W-1:0] prod_rnd;
  logic [ENV_W-1:0] m_d, level_d;
  logic [EXT_W-1:0] phase_ext;

  always_comb begin
    prod_rnd  = rnd_frac(prod_q);
    m_d       = (prod_rnd > RND_W'(ENV_ONE)) ? ENV_ONE : prod_rnd[ENV_W-1:0];
    level_d   = ENV_ONE - prod_rnd[ENV_W-1:0];
    phase_ext = EXT_W'(phase_q);
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_q  <= ATK_RESET;
      release_q <= REL_RESET;
      speed_q   <= SPD_RESET;
      amount_q  <= AMT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ATTACK:  attack_q  <= cfg_data_i[ATK_W-1:0];
        CFG_RELEASE: release_q <= cfg_data_i[REL_W-1:0];
        CFG_SPEED:   speed_q   <= cfg_data_i[SPD_W-1:0];
        CFG_AMOUNT:  amount_q  <= cfg_data_i[AMT_W-1:0];
        default: ;
      endcase
    end
  end

  // Tick state: edge history, one-shot, envelope, phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gate_held_q <= 1'b0;
      trig_last_q <= 1'b0;
      armed_q     <= 1'b0;
      env_q       <= '0;
      phase_q     <= '0;
    end else begin
      if (cmd_i.accept) begin
        gate_held_q <= in_data_i.gate_level;
        trig_last_q <= in_data_i.trigger_level;
        armed_q     <= os_edge;
      end else if (cmd_i.env_upd) begin
        armed_q     <= armed_d;
      end
      if (cmd_i.env_upd) begin
        env_q <= env_d;
      end
      if (cmd_i.cap_phase) begin
        phase_q <= phase_d;
      end
    end
  end

  // Per-request working values
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      dt_q     <= in_data_i.time_step;
      active_q <= active_in;
    end
    if (cmd_i.cap_q) begin
      sq_q <= prod_rnd[ENV_W-1:0];
    end
    if (cmd_i.cap_m) begin
      m_q <= m_d;
    end
  end

  // Output register: load when free, drop valid once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.envelope    <= env_q;
      out_q.level       <= level_d;
      out_q.drift_phase <= phase_ext[PHASE_OUT_W-1:0];
    end
  end

  assign sts_o.div_done = div_done;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_q;

endmodule

@@ hdl/gated_ar_envelope_with_phase_drift.sv @@
`timescale 1ns / 1ps
// Flow: a request passes through the divider (32 divider steps), the envelope
//   update, the square, phase, smoothstep, curve and blend steps on the shared
//   multiplier and the output load, which waits while the output register is full.
// One request is in flight at a time; a new request is taken while a result waits.
// Reset (rst_ni low, asynchronous): envelope, phase and edge history clear,
//   registers return to their defaults, no result is pending.
module gated_ar_envelope_with_phase_drift #(
  parameter int PHASE_WRAP_RINGS = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [gaenv_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [gaenv_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  gaenv_pkg::in_req_t                in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output gaenv_pkg::out_req_t               out_data_o
);
  import gaenv_pkg::*;

  cmd_t cmd;
  sts_t sts;

  gaenv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  gaenv_dp #(
    .PHASE_WRAP_RINGS (PHASE_WRAP_RINGS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

@@ hdl/gaenv_chk.sv @@
`timescale 1ns / 1ps

module gaenv_chk (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input gaenv_pkg::out_req_t out_data_o
);
  import gaenv_pkg::*;

  // A stalled result holds its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // One request in flight: accepting stalls the input next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second request accepted while busy");

  // Envelope and level stay within full scale
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.envelope <= ENV_ONE && out_data_o.level <= ENV_ONE)
    else $error("result beyond full scale");

  // A full envelope gives a full level whatever the floor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.envelope == ENV_ONE |-> out_data_o.level == ENV_ONE)
    else $error("full envelope without full level");

endmodule

bind gated_ar_envelope_with_phase_drift gaenv_chk u_gaenv_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

@@ test/envelope_checker.sv @@
`timescale 1ns / 1ps

// Watches the request and result channels and the register port, predicts the
// envelope, level and drift phase of every accepted request, and compares each
// accepted result against the oldest pending prediction.
module envelope_checker #(
  parameter int PHASE_WRAP_RINGS = 1024
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [gaenv_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [gaenv_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                             in_valid_i,
  input  logic                             in_stall_i,
  input  gaenv_pkg::in_req_t               in_data_i,
  input  logic                             out_valid_i,
  input  logic                             out_stall_i,
  input  gaenv_pkg::out_req_t              out_data_i,
  output int unsigned                      fail_count_o,
  output int unsigned                      pending_o
);

  import gaenv_pkg::*;

  localparam longint unsigned FULL_SCALE = 64'd1 << ENV_FRAC_BITS;
  localparam longint unsigned HALF_LSB   = 64'd1 << (ENV_FRAC_BITS - 1);
  localparam longint unsigned PHASE_MOD  = 64'(PHASE_WRAP_RINGS) << PHASE_FRAC_BITS;
  localparam longint unsigned PHASE_RND  = 64'd1 << (PHASE_SHIFT - 1);

  // Shadow registers and envelope state
  logic [ATK_W-1:0] attack_r;
  logic [REL_W-1:0] release_r;
  logic [SPD_W-1:0] speed_r;
  logic [AMT_W-1:0] amount_r;
  logic             gate_seen;
  logic             trigger_seen;
  logic             pulse_armed;
  longint unsigned  env_acc;
  longint unsigned  phase_acc;
  out_req_t         predicted_results[$];

  function automatic longint unsigned round_frac(longint unsigned v);
    return (v + HALF_LSB) >> ENV_FRAC_BITS;
  endfunction

  // Advance the envelope and phase by one tick and form the result
  function automatic out_req_t predict_tick(in_req_t req);
    longint unsigned dt, step, amt, x, q, m, mix, sum;
    out_req_t        res;
    dt = 64'(req.time_step);
    if (req.gate_level && !gate_seen) pulse_armed = 1'b0;
    gate_seen = req.gate_level;
    if (req.trigger_level && !trigger_seen) pulse_armed = 1'b1;
    trigger_seen = req.trigger_level;

    if (gate_seen || pulse_armed) begin
      if (attack_r <= ENV_JUMP_LIMIT) env_acc = FULL_SCALE;
      else env_acc = env_acc + (dt << ENV_FRAC_BITS) / 64'(attack_r);
      if (env_acc >= FULL_SCALE) begin
        env_acc     = FULL_SCALE;
        pulse_armed = 1'b0;
      end
    end else if (release_r <= ENV_JUMP_LIMIT) begin
      env_acc = 0;
    end else begin
      step    = (dt << ENV_FRAC_BITS) / 64'(release_r);
      env_acc = (env_acc > step) ? env_acc - step : 0;
    end

    // Accumulate drift and wrap
    sum = phase_acc + ((dt * 64'(speed_r) + PHASE_RND) >> PHASE_SHIFT);
    phase_acc = sum % PHASE_MOD;

    // Ease the envelope and blend with the manual floor
    amt = (64'(amount_r) > FULL_SCALE) ? FULL_SCALE : 64'(amount_r);
    x   = env_acc;
    q   = round_frac(x * x);
    m   = round_frac(q * (3 * FULL_SCALE - 2 * x));
    if (m > FULL_SCALE) m = FULL_SCALE;
    mix = FULL_SCALE - round_frac((FULL_SCALE - amt) * (FULL_SCALE - m));

    res.envelope    = ENV_W'(env_acc);
    res.level       = ENV_W'(mix);
    res.drift_phase = PHASE_OUT_W'(phase_acc);
    return res;
  endfunction

  task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
    $display("%0t ns: %s mismatch, got %0d want %0d", $time, field, got, want);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_req_t want;
    if (!rst_ni) begin
      attack_r        = ATK_RESET;
      release_r       = REL_RESET;
      speed_r         = SPD_RESET;
      amount_r        = AMT_RESET;
      gate_seen       = 1'b0;
      trigger_seen    = 1'b0;
      pulse_armed     = 1'b0;
      env_acc         = 0;
      phase_acc       = 0;
      fail_count_o    = 0;
      pending_o       = 0;
      predicted_results.delete();
    end else begin
      // Track register writes
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_ATTACK:  attack_r  = ATK_W'(cfg_data_i);
          CFG_RELEASE: release_r = REL_W'(cfg_data_i);
          CFG_SPEED:   speed_r   = SPD_W'(cfg_data_i);
          CFG_AMOUNT:  amount_r  = AMT_W'(cfg_data_i);
          default: ;
        endcase
      end

      // Compare an accepted result against the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        if (predicted_results.size() == 0) begin
          $display("%0t ns: result with no pending request", $time);
          fail_count_o++;
        end else begin
          want = predicted_results.pop_front();
          if (out_data_i.envelope !== want.envelope)
            report_mismatch("envelope", out_data_i.envelope, want.envelope);
          if (out_data_i.level !== want.level)
            report_mismatch("level", out_data_i.level, want.level);
          if (out_data_i.drift_phase !== want.drift_phase)
            report_mismatch("drift_phase", out_data_i.drift_phase, want.drift_phase);
        end
      end

      // Predict each accepted request
      if (in_valid_i && !in_stall_i) predicted_results.push_back(predict_tick(in_data_i));
      pending_o = predicted_results.size();
    end
  end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

  import gaenv_pkg::*;

  localparam int          RANDOM_ITEMS = 1000;
  localparam int          DRAIN_CYCLES = 60;
  localparam int unsigned FULL_SCALE   = 1 << ENV_FRAC_BITS;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = CFG_ATTACK;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  in_req_t               in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_req_t              out_data_o;

  int unsigned fail_count;
  int unsigned pending;

  // Receiver stall pattern state
  logic [1:0]  stall_mode;
  int unsigned stall_left;

  gated_ar_envelope_with_phase_drift uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  envelope_checker checker_inst (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .in_data_i      (in_data_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_data_i     (out_data_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Receiver: switch between no stall, random stall and long stall runs
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_mode  <= 2'd0;
      stall_left  <= 0;
    end else begin
      if (stall_left == 0) begin
        stall_mode <= 2'($urandom_range(0, 2));
        stall_left <= $urandom_range(50, 300);
      end else begin
        stall_left <= stall_left - 1;
      end
      case (stall_mode)
        2'd1:    out_stall_i <= ($urandom_range(0, 2) == 0);
        2'd2:    out_stall_i <= ($urandom_range(0, 39) == 0) ? ~out_stall_i : out_stall_i;
        default: out_stall_i <= 1'b0;
      endcase
    end
  end

  function automatic in_req_t tick(logic gate, logic trig, logic [DT_W-1:0] dt);
    in_req_t r;
    r.gate_level    = gate;
    r.trigger_level = trig;
    r.time_step     = dt;
    return r;
  endfunction

  // Hold the request until it is accepted
  task automatic send_tick(input in_req_t r);
    in_valid_i <= 1'b1;
    in_data_i  <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Drop valid and wait until every predicted result has come back
  task automatic wait_all_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input int unsigned value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CFG_DATA_W'(value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Ramp time: jump range, just above it, the field maximum, the given top, or a random magnitude
  function automatic int unsigned pick_time(int width, int unsigned top);
    int unsigned v;
    case ($urandom_range(0, 7))
      0:       v = $urandom_range(0, ENV_JUMP_LIMIT);
      1:       v = ENV_JUMP_LIMIT + 1;
      2:       v = (1 << width) - 1;
      3:       v = top;
      default: v = $urandom & ((1 << $urandom_range(3, width)) - 1);
    endcase
    return v;
  endfunction

  function automatic int unsigned pick_amount();
    int unsigned v;
    case ($urandom_range(0, 5))
      0:       v = 0;
      1:       v = FULL_SCALE;
      2:       v = (1 << AMT_W) - 1;
      default: v = $urandom_range(0, FULL_SCALE);
    endcase
    return v;
  endfunction

  initial begin
    int unsigned sent, burst_left, gap, phase_len, sel;
    logic        gate_lvl, trig_lvl, fast_drift;
    logic [DT_W-1:0] dt;
    sent       = 0;
    burst_left = 0;
    gate_lvl   = 1'b0;
    trig_lvl   = 1'b0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Default registers: gate attack, release, one-shot, gate and trigger together
    send_tick(tick(1'b0, 1'b0, 16'd0));
    send_tick(tick(1'b1, 1'b0, 16'hFFFF));
    send_tick(tick(1'b1, 1'b0, 16'd1000));
    send_tick(tick(1'b0, 1'b0, 16'hFFFF));
    send_tick(tick(1'b0, 1'b0, 16'd1));
    send_tick(tick(1'b0, 1'b1, 16'd100));
    send_tick(tick(1'b0, 1'b1, 16'd100));
    send_tick(tick(1'b0, 1'b0, 16'hFFFF));
    send_tick(tick(1'b0, 1'b0, 16'd3000));
    send_tick(tick(1'b1, 1'b1, 16'd200));
    send_tick(tick(1'b0, 1'b0, 16'd200));

    // Short times jump at once; manual floor saturates; fastest drift
    wait_all_results();
    write_reg(CFG_ATTACK, ENV_JUMP_LIMIT);
    write_reg(CFG_RELEASE, ENV_JUMP_LIMIT);
    write_reg(CFG_AMOUNT, (1 << AMT_W) - 1);
    write_reg(CFG_SPEED, (1 << SPD_W) - 1);
    send_tick(tick(1'b0, 1'b1, 16'd0));
    send_tick(tick(1'b0, 1'b0, 16'd0));
    send_tick(tick(1'b1, 1'b0, 16'hFFFF));

    // Longest times: steps that round to zero, no drift
    wait_all_results();
    write_reg(CFG_ATTACK, (1 << ATK_W) - 1);
    write_reg(CFG_RELEASE, (1 << REL_W) - 1);
    write_reg(CFG_AMOUNT, 30000);
    write_reg(CFG_SPEED, 0);
    send_tick(tick(1'b1, 1'b0, 16'd1));
    send_tick(tick(1'b0, 1'b0, 16'd1));
    send_tick(tick(1'b1, 1'b0, 16'hFFFF));
    send_tick(tick(1'b0, 1'b0, 16'hFFFF));

    // Zero attack, release just past the jump limit
    wait_all_results();
    write_reg(CFG_ATTACK, 0);
    write_reg(CFG_RELEASE, ENV_JUMP_LIMIT + 1);
    write_reg(CFG_SPEED, FULL_SCALE);
    write_reg(CFG_AMOUNT, FULL_SCALE);
    send_tick(tick(1'b1, 1'b0, 16'hFFFF));
    send_tick(tick(1'b0, 1'b0, 16'(ENV_JUMP_LIMIT + 1)));

    // Random phases with fresh register settings
    while (sent < RANDOM_ITEMS) begin
      wait_all_results();
      fast_drift = ($urandom_range(0, 9) < 8);
      write_reg(CFG_SPEED, fast_drift ? (1 << SPD_W) - 1 : $urandom_range(0, (1 << SPD_W) - 1));
      if ($urandom_range(0, 1)) write_reg(CFG_ATTACK, pick_time(ATK_W, FULL_SCALE));
      if ($urandom_range(0, 1)) write_reg(CFG_RELEASE, pick_time(REL_W, 5 * FULL_SCALE));
      if ($urandom_range(0, 2) == 0) write_reg(CFG_AMOUNT, pick_amount());

      phase_len = $urandom_range(20, 80);
      repeat (phase_len) begin
        // Bursts with random gaps, some back to back
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
          if (gap != 0) begin
            in_valid_i <= 1'b0;
            repeat (gap) @(posedge clk_i);
          end
        end
        burst_left--;

        // Gate held in runs, trigger pulsing, occasional noise
        if ($urandom_range(0, 9) == 0) begin
          gate_lvl = 1'($urandom);
          trig_lvl = 1'($urandom);
        end else begin
          if ($urandom_range(0, 7) == 0) gate_lvl = ~gate_lvl;
          if ($urandom_range(0, 3) == 0) trig_lvl = ~trig_lvl;
        end

        sel = $urandom_range(0, 19);
        if (fast_drift) begin
          if (sel < 15)      dt = 16'($urandom_range(49152, 65535));
          else if (sel < 18) dt = 16'($urandom);
          else               dt = 16'($urandom_range(0, 15));
        end else begin
          if (sel < 8)       dt = 16'($urandom_range(0, 255));
          else if (sel < 16) dt = 16'($urandom_range(0, 4095));
          else               dt = 16'($urandom);
        end

        send_tick(tick(gate_lvl, trig_lvl, dt));
        sent++;
      end
    end

    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
